### hdl/acrc_pkg.sv
// Shared types, codes and constants of the associative cache replacement classifier.
`default_nettype none
package acrc_pkg;

  localparam int WAYS_DEF     = 16;
  localparam int TAG_BITS_DEF = 10;
  localparam int IDX_MAX_W    = 6;   // way index, up to 64 ways
  localparam int CAP_MAX_W    = 7;   // way count, up to 64
  localparam int CNT_W        = 32;
  localparam int POLICY_W     = 2;
  localparam int CAPACITY_W   = 5;
  localparam int CFG_W        = 5;
  localparam int SEEN_ROW_LOG = 4;
  localparam int SEEN_ROW_W   = 1 << SEEN_ROW_LOG;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef logic [IDX_MAX_W-1:0] widx_t;
  typedef logic [CAP_MAX_W-1:0] wcnt_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIFO  = 2'd0,
    POL_LRU   = 2'd1,
    POL_CLOCK = 2'd2
  } policy_e;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_COMP = 2'd1,
    KIND_CAPM = 2'd2
  } miss_kind_e;

  // Search record carried down the cell chain.
  typedef struct packed {
    logic  hit_f;
    widx_t hit_idx;
    widx_t hit_rank;
    logic  free_f;
    widx_t free_idx;
    widx_t old_idx;
    widx_t old_rank;
    logic  ge_f;
    widx_t ge_idx;
    widx_t ge_rank;
    logic  any_f;
    widx_t any_idx;
    widx_t any_rank;
    widx_t hand_rank;
  } sweep_t;

  // Update broadcast to all cells at commit.
  typedef struct packed {
    logic  en;
    logic  fill;
    logic  hit_lru;
    logic  hit_clk;
    widx_t tgt;
    logic  age;
    logic  age_all;
    widx_t below;
    logic  clr;
    logic  clr_all;
    logic  clr_wrap;
    widx_t clr_lo;
    widx_t clr_hi;
  } upd_t;

endpackage
`default_nettype wire

### hdl/acrc_cell.sv
// One cache way: tag storage, replacement state and one stage of the search chain.
`default_nettype none
module acrc_cell import acrc_pkg::*; #(
  parameter int WAYS     = WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  parameter int K        = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [TAG_BITS-1:0] q_tag_i,
  input  wire wcnt_t               q_cap_i,
  input  wire widx_t               q_hand_i,
  input  wire sweep_t              sw_i,
  output      sweep_t              sw_o,
  input  wire upd_t                upd_i
);

  localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [RW-1:0] RMAX = RW'(WAYS - 1);
  localparam widx_t KI = widx_t'(K);
  localparam wcnt_t KC = wcnt_t'(K);

  logic [TAG_BITS-1:0] tag_q;
  logic                valid_q;
  logic [RW-1:0]       rank_q;
  logic                ref_q;
  sweep_t              sw_q, sw_d;

  logic  active, is_tgt, in_rng, do_age;
  widx_t rank_x;

  assign active = KC < q_cap_i;
  assign rank_x = widx_t'(rank_q);

  always_comb begin
    sw_d = sw_i;
    if (KI == q_hand_i) begin
      sw_d.hand_rank = rank_x;
    end
    if (active) begin
      if (valid_q && tag_q == q_tag_i && !sw_i.hit_f) begin
        sw_d.hit_f    = 1'b1;
        sw_d.hit_idx  = KI;
        sw_d.hit_rank = rank_x;
      end
      if (!valid_q && !sw_i.free_f) begin
        sw_d.free_f   = 1'b1;
        sw_d.free_idx = KI;
      end
      if (rank_x > sw_i.old_rank) begin
        sw_d.old_idx  = KI;
        sw_d.old_rank = rank_x;
      end
      if (!ref_q && KI >= q_hand_i && !sw_i.ge_f) begin
        sw_d.ge_f    = 1'b1;
        sw_d.ge_idx  = KI;
        sw_d.ge_rank = rank_x;
      end
      if (!ref_q && !sw_i.any_f) begin
        sw_d.any_f    = 1'b1;
        sw_d.any_idx  = KI;
        sw_d.any_rank = rank_x;
      end
    end
  end

  assign sw_o   = sw_q;
  assign is_tgt = KI == upd_i.tgt;
  assign in_rng = upd_i.clr_all ||
                  (upd_i.clr_wrap ? (KI >= upd_i.clr_lo || KI < upd_i.clr_hi)
                                  : (KI >= upd_i.clr_lo && KI < upd_i.clr_hi));
  assign do_age = upd_i.age && active && valid_q && rank_q != RMAX &&
                  (upd_i.age_all || rank_x < upd_i.below);

  always_ff @(posedge clk_i) begin
    sw_q <= sw_d;
    if (upd_i.en && upd_i.fill && is_tgt) begin
      tag_q <= q_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      ref_q   <= 1'b0;
    end else if (upd_i.en) begin
      if (is_tgt) begin
        if (upd_i.fill) begin
          valid_q <= 1'b1;
          rank_q  <= '0;
          ref_q   <= 1'b0;
        end else begin
          if (upd_i.hit_lru) rank_q <= '0;
          if (upd_i.hit_clk) ref_q <= 1'b1;
        end
      end else begin
        if (do_age) rank_q <= rank_q + RW'(1);
        if (upd_i.clr && active && in_rng) ref_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/acrc_seen.sv
// Seen-tag bitmap: row memory with read-modify-write set and a clearing pass after reset.
`default_nettype none
module acrc_seen import acrc_pkg::*; #(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [TAG_BITS-1:0] tag_i,
  input  wire logic                rd_en_i,
  input  wire logic                wr_en_i,
  output      logic                seen_o,
  output      logic                busy_o
);

  localparam int ROWS = 1 << (TAG_BITS - SEEN_ROW_LOG);
  localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [SEEN_ROW_W-1:0]   mem_q [ROWS];
  logic [SEEN_ROW_W-1:0]   rd_q;
  logic                    clr_q;
  logic [RIW-1:0]          clr_row_q;
  logic [RIW-1:0]          row_a;
  logic [SEEN_ROW_LOG-1:0] bit_a;

  assign row_a  = RIW'(tag_i >> SEEN_ROW_LOG);
  assign bit_a  = tag_i[SEEN_ROW_LOG-1:0];
  assign seen_o = rd_q[bit_a];
  assign busy_o = clr_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_row_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[row_a] <= rd_q | (SEEN_ROW_W'(1) << bit_a);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_q <= mem_q[row_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else if (clr_q) begin
      if (clr_row_q == RIW'(ROWS - 1)) clr_q <= 1'b0;
      else clr_row_q <= clr_row_q + RIW'(1);
    end
  end

endmodule
`default_nettype wire

### hdl/assoc_cache_replacement_classifier_unit.sv
// Top level of the associative cache replacement classifier.
// Usage:
//   Input channel (in_valid_i/in_ready_o, tag_i) carries one access tag per
//   transaction. Output channel (out_valid_o/out_ready_i) returns hit,
//   miss_kind and the two saturating miss totals for that access.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 policy, 1 capacity); write only while idle.
//   An access runs down a chain of WAYS way cells, one cell per cycle,
//   then commits: the result is registered at commit, and a new access
//   is taken the cycle after commit; the chain length sets how long an
//   access takes.
//   One access is in flight at a time; a finished result may wait in the
//   output register while the next access is taken and searched. Commit
//   waits while a previous result is still held by a stalled receiver.
//   Reset clears way state and counters and restores the config defaults
//   (FIFO, capacity 16); the seen bitmap is then cleared one 16-bit row per
//   cycle, 2^(TAG_BITS-4) rows (64 at 10 bits), with in_ready_o low until done.
`default_nettype none
module assoc_cache_replacement_classifier_unit import acrc_pkg::*; #(
  parameter int WAYS     = WAYS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [TAG_BITS-1:0]   tag_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  hit_o,
  output      logic [1:0]            miss_kind_o,
  output      logic [CNT_W-1:0]      compulsory_total_o,
  output      logic [CNT_W-1:0]      capacity_total_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [IW-1:0]         cnt_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [POLICY_W-1:0]   policy_q;
  logic [CAPACITY_W-1:0] capacity_q;
  widx_t                 hand_q;
  logic [CNT_W-1:0]      comp_q, capm_q;
  logic                  out_valid_q, hit_q;
  logic [1:0]            kind_q;

  wcnt_t  cap_ext, cap_c;
  widx_t  hand_eff, vclk, vclk_rank, hand_nxt;
  sweep_t sw [WAYS+1];
  sweep_t r;
  upd_t   upd;
  logic   in_fire, commit, is_lru, is_clk, seen, seen_busy;
  logic [1:0] kind_c;

  assign cap_ext  = wcnt_t'(capacity_q);
  assign cap_c    = (cap_ext == '0) ? wcnt_t'(1) :
                    (cap_ext > wcnt_t'(WAYS)) ? wcnt_t'(WAYS) : cap_ext;
  assign hand_eff = (wcnt_t'(hand_q) >= cap_c) ? '0 : hand_q;

  assign in_ready_o = state_q == ST_IDLE && !seen_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit     = state_q == ST_COMMIT && (!out_valid_q || out_ready_i);

  assign sw[0] = '0;
  for (genvar k = 0; k < WAYS; k++) begin : g_way
    acrc_cell #(
      .WAYS    (WAYS),
      .TAG_BITS(TAG_BITS),
      .K       (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .q_tag_i (tag_q),
      .q_cap_i (cap_c),
      .q_hand_i(hand_eff),
      .sw_i    (sw[k]),
      .sw_o    (sw[k+1]),
      .upd_i   (upd)
    );
  end
  assign r = sw[WAYS];

  acrc_seen #(
    .TAG_BITS(TAG_BITS)
  ) u_seen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_q),
    .rd_en_i(state_q == ST_SWEEP),
    .wr_en_i(commit && !r.hit_f),
    .seen_o (seen),
    .busy_o (seen_busy)
  );

  assign is_lru = policy_q == POL_LRU;
  assign is_clk = policy_q == POL_CLOCK;

  // clock victim: first clear ref at or after the hand, else first clear, else the hand
  assign vclk      = r.ge_f ? r.ge_idx : (r.any_f ? r.any_idx : hand_eff);
  assign vclk_rank = r.ge_f ? r.ge_rank : (r.any_f ? r.any_rank : r.hand_rank);
  assign hand_nxt  = (wcnt_t'(vclk) + wcnt_t'(1) >= cap_c) ? '0 : vclk + widx_t'(1);

  always_comb begin
    upd    = '0;
    upd.en = commit;
    if (r.hit_f) begin
      upd.tgt     = r.hit_idx;
      upd.hit_lru = is_lru;
      upd.hit_clk = is_clk;
      upd.age     = is_lru;
      upd.below   = r.hit_rank;
    end else begin
      upd.fill = 1'b1;
      upd.age  = 1'b1;
      if (r.free_f) begin
        upd.tgt     = r.free_idx;
        upd.age_all = 1'b1;
      end else if (is_clk) begin
        upd.tgt      = vclk;
        upd.below    = vclk_rank;
        upd.clr      = 1'b1;
        upd.clr_all  = !r.ge_f && !r.any_f;
        upd.clr_wrap = !r.ge_f;
        upd.clr_lo   = hand_eff;
        upd.clr_hi   = vclk;
      end else begin
        upd.tgt   = r.old_idx;
        upd.below = r.old_rank;
      end
    end
  end

  assign kind_c = r.hit_f ? KIND_HIT : (seen ? KIND_CAPM : KIND_COMP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_SWEEP;
      ST_SWEEP:  if (cnt_q == IW'(WAYS - 1)) state_d = ST_COMMIT;
      ST_COMMIT: if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) tag_q <= tag_i;
    if (commit) begin
      hit_q  <= r.hit_f;
      kind_q <= kind_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      policy_q    <= POL_FIFO;
      capacity_q  <= CAPACITY_W'(16);
      hand_q      <= '0;
      comp_q      <= '0;
      capm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) cnt_q <= '0;
      else if (state_q == ST_SWEEP) cnt_q <= cnt_q + IW'(1);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLICY:   policy_q   <= cfg_wdata_i[POLICY_W-1:0];
          REG_CAPACITY: capacity_q <= cfg_wdata_i[CAPACITY_W-1:0];
          default:      ;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (!r.hit_f && !r.free_f && is_clk) hand_q <= hand_nxt;
        if (kind_c == KIND_COMP && comp_q != '1) comp_q <= comp_q + CNT_W'(1);
        if (kind_c == KIND_CAPM && capm_q != '1) capm_q <= capm_q + CNT_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign miss_kind_o        = kind_q;
  assign compulsory_total_o = comp_q;
  assign capacity_total_o   = capm_q;

endmodule
`default_nettype wire

### hdl/acrc_checker.sv
// Port-level checker for the classifier, bound to the top level.
`default_nettype none
module acrc_checker import acrc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic             hit_o,
  input wire logic [1:0]       miss_kind_o,
  input wire logic [CNT_W-1:0] compulsory_total_o,
  input wire logic [CNT_W-1:0] capacity_total_o
);

  // one access in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an access is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(miss_kind_o))
    else $error("stalled result changed");

  a_hit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (miss_kind_o == KIND_HIT)))
    else $error("hit flag and miss kind disagree");

  a_comp_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(compulsory_total_o) |-> out_valid_o && miss_kind_o == KIND_COMP)
    else $error("compulsory total moved without a compulsory miss");

  a_capm_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(capacity_total_o) |-> out_valid_o && miss_kind_o == KIND_CAPM)
    else $error("capacity total moved without a capacity miss");

endmodule

bind assoc_cache_replacement_classifier_unit acrc_checker u_acrc_checker (.*);
`default_nettype wire

### sim/tb_top.sv
// Testbench for the associative cache replacement classifier: queue-fed driver, predictor, monitor.
`timescale 1ns / 100ps
module tb_top;
  import acrc_pkg::*;

  localparam int NWAYS   = 16;
  localparam int TAGW    = 10;
  localparam int RANKMAX = NWAYS - 1;
  localparam int WDOG    = 20000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [TAGW-1:0]  tag_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             hit_o;
  logic [1:0]       miss_kind_o;
  logic [31:0]      compulsory_total_o;
  logic [31:0]      capacity_total_o;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_POLICY;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  assoc_cache_replacement_classifier_unit #(.WAYS(NWAYS), .TAG_BITS(TAGW)) uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct packed {
    logic        hit;
    miss_kind_e  kind;
    logic [31:0] comp;
    logic [31:0] capm;
  } access_res_t;

  // cache model state
  logic [1:0]      pol;
  logic [4:0]      cap_reg;
  logic [TAGW-1:0] m_tag [NWAYS];
  logic            m_vld [NWAYS];
  int unsigned     m_rank [NWAYS];
  logic            m_ref [NWAYS];
  int unsigned     m_hand;
  logic            m_seen [1 << TAGW];
  logic [31:0]     m_comp, m_capm;

  logic [TAGW-1:0] tag_q [$];
  access_res_t     expected_q [$];
  bit              failed = 0;
  bit              idle_en = 0;
  bit              hold_src = 0;
  int              wdog = 0;

  function automatic void age_ways(int unsigned cap, int unsigned skip, int unsigned lim);
    for (int unsigned i = 0; i < cap; i++)
      if (i != skip && m_vld[i] && m_rank[i] < lim && m_rank[i] < RANKMAX) m_rank[i]++;
  endfunction

  function automatic access_res_t cache_access(logic [TAGW-1:0] t);
    access_res_t r;
    int unsigned cap, way, vic, n, h;
    bit found;
    cap = (cap_reg == 0) ? 1 : (cap_reg > NWAYS ? NWAYS : cap_reg);
    found = 0;
    way = 0;
    for (int unsigned i = 0; i < cap; i++)
      if (!found && m_vld[i] && m_tag[i] == t) begin
        found = 1;
        way = i;
      end
    if (found) begin
      r.kind = KIND_HIT;
      if (pol == POL_LRU) begin
        age_ways(cap, way, m_rank[way]);
        m_rank[way] = 0;
      end else if (pol == POL_CLOCK) begin
        m_ref[way] = 1'b1;
      end
    end else begin
      if (m_seen[t]) begin
        r.kind = KIND_CAPM;
        if (m_capm != 32'hFFFF_FFFF) m_capm++;
      end else begin
        r.kind = KIND_COMP;
        if (m_comp != 32'hFFFF_FFFF) m_comp++;
      end
      m_seen[t] = 1'b1;
      vic = cap;
      for (int unsigned i = 0; i < cap; i++)
        if (vic == cap && !m_vld[i]) vic = i;
      if (vic < cap) begin
        age_ways(cap, vic, 32'hFFFF_FFFF);
      end else begin
        if (pol == POL_CLOCK) begin
          h = (m_hand >= cap) ? 0 : m_hand;
          for (n = 0; n < 2 * cap; n++) begin
            if (!m_ref[h]) break;
            m_ref[h] = 1'b0;
            h = (h + 1 >= cap) ? 0 : h + 1;
          end
          m_hand = (h + 1 >= cap) ? 0 : h + 1;
          vic = h;
        end else begin
          vic = 0;
          for (int unsigned i = 1; i < cap; i++)
            if (m_rank[i] > m_rank[vic]) vic = i;
        end
        age_ways(cap, vic, m_rank[vic]);
      end
      m_tag[vic] = t;
      m_vld[vic] = 1'b1;
      m_rank[vic] = 0;
      m_ref[vic] = 1'b0;
    end
    r.hit = found;
    r.comp = m_comp;
    r.capm = m_capm;
    return r;
  endfunction

  // driver
  logic accepted_in;
  always @(posedge clk_i) accepted_in <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_in) begin
        if (tag_q.size() > 0 && !hold_src && !(idle_en && $urandom_range(99) < 25)) begin
          in_valid_i <= 1'b1;
          tag_i <= tag_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !(idle_en && $urandom_range(99) < 25);
    end
  end

  // predictor fed at the accepting edge, monitor checks output transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_q.push_back(cache_access(tag_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b kind=%0d", $time, hit_o, miss_kind_o);
          failed = 1;
        end else begin
          access_res_t e;
          e = expected_q.pop_front();
          if (hit_o !== e.hit || miss_kind_o !== e.kind || compulsory_total_o !== e.comp ||
              capacity_total_o !== e.capm) begin
            $display("%0t: mismatch exp hit=%0b kind=%0d comp=%0d capm=%0d", $time,
                     e.hit, e.kind, e.comp, e.capm);
            $display("%0t:          act hit=%0b kind=%0d comp=%0d capm=%0d", $time,
                     hit_o, miss_kind_o, compulsory_total_o, capacity_total_o);
            failed = 1;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG) begin
        $display("assoc_cache_replacement_classifier_unit test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_POLICY) pol = val[1:0];
    else cap_reg = val;
  endtask

  task automatic drain();
    while (tag_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (NWAYS + 6) @(posedge clk_i);
  endtask

  // mostly a working set near the capacity so all three outcomes show up
  task automatic load_random(int n, int span);
    int unsigned base;
    base = $urandom_range(1023);
    repeat (n) begin
      if ($urandom_range(9) == 0) tag_q.push_back(TAGW'($urandom_range(1023)));
      else tag_q.push_back(TAGW'((base + $urandom_range(span)) % 1024));
    end
  endtask

  initial begin
    logic [1:0] pols [6];
    logic [4:0] caps [6];
    pol = 0;
    cap_reg = 16;
    m_hand = 0;
    m_comp = 0;
    m_capm = 0;
    for (int i = 0; i < NWAYS; i++) begin
      m_tag[i] = '0;
      m_vld[i] = 0;
      m_rank[i] = 0;
      m_ref[i] = 0;
    end
    for (int i = 0; i < (1 << TAGW); i++) m_seen[i] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme tags, hits, capacity misses at tiny capacity
    write_reg(REG_CAPACITY, 5'd2);
    tag_q = '{10'd0, 10'd1023, 10'd0, 10'h155, 10'h2AA, 10'd1023, 10'd0, 10'h155};
    drain();
    write_reg(REG_POLICY, 5'd3);   // unused code acts as fifo
    write_reg(REG_CAPACITY, 5'd0); // treated as one way
    tag_q = '{10'd7, 10'd7, 10'd8, 10'd7};
    drain();
    write_reg(REG_POLICY, CFG_W'(POL_CLOCK));
    write_reg(REG_CAPACITY, 5'd31); // clamped to all ways
    tag_q = '{10'd3, 10'd3, 10'd9, 10'd1023};
    drain();
    write_reg(REG_POLICY, CFG_W'(POL_LRU));
    write_reg(REG_CAPACITY, 5'd3);
    tag_q = '{10'd0, 10'd1, 10'd0, 10'd2, 10'd5};
    drain();

    pols = '{POL_FIFO, POL_LRU, POL_CLOCK, POL_LRU, POL_CLOCK, POL_FIFO};
    caps = '{5'd16, 5'd4, 5'd1, 5'd8, 5'd16, 5'd5};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_POLICY, CFG_W'(pols[p]));
      write_reg(REG_CAPACITY, caps[p]);
      idle_en = (p != 2);
      load_random(115, caps[p] + caps[p] / 2 + 1);
      if (p == 3) begin
        load_random(60, 6);
        // sender holds off until the pipeline is empty
        while (tag_q.size() > 60 || in_valid_i || expected_q.size() > 0) begin
          hold_src = (tag_q.size() <= 60);
          @(posedge clk_i);
        end
        hold_src = 0;
      end
      drain();
    end
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_POLICY, CFG_W'($urandom_range(3)));
      write_reg(REG_CAPACITY, CFG_W'($urandom_range(31)));
      idle_en = 1;
      load_random(115, $urandom_range(24));
      drain();
    end
    if (!failed) $display("assoc_cache_replacement_classifier_unit test passed");
    else $display("assoc_cache_replacement_classifier_unit test failed");
    $finish;
  end
endmodule
